// File: sv/lrt_pkg.sv
// Shared constants, types and the micro-op table of the Lorenz RK4 tracker.
`timescale 1ns / 1ps

package lrt_pkg;

    // Fixed-point word format
    localparam int WORD_BITS = 48;
    localparam int FRAC_BITS = 36;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SSQ_BITS  = PROD_BITS + 2;
    localparam int ROOT_BITS = (SSQ_BITS + 2) / 2;
    localparam int COEF_BITS = 47;
    localparam int STEP_BITS = 37;
    localparam int CNT_BITS  = 32;

    // floor(x/6) = (x * H6_MAGIC) >> H6_SHIFT, exact for 37-bit x
    localparam int H6_SHIFT = 40;
    localparam logic [37:0] H6_MAGIC = 38'd183251937963;

    // Register reset values
    localparam logic [COEF_BITS-1:0] SIGMA_RST  = 47'd687194767360;
    localparam logic [COEF_BITS-1:0] RHO_RST    = 47'd1924145348608;
    localparam logic [COEF_BITS-1:0] BETA_RST   = 47'd183251937963;
    localparam logic [STEP_BITS-1:0] STEP_RST   = 37'd343597384;
    localparam logic [STEP_BITS-1:0] OFFSET_RST = 37'd687;

    // Register indexes
    localparam logic [2:0] CFG_SIGMA  = 3'd0;
    localparam logic [2:0] CFG_RHO    = 3'd1;
    localparam logic [2:0] CFG_BETA   = 3'd2;
    localparam logic [2:0] CFG_STEP   = 3'd3;
    localparam logic [2:0] CFG_OFFSET = 3'd4;

    // Modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_WARM   = 2'd1;
    localparam logic [1:0] MODE_RECORD = 2'd2;

    typedef logic signed [WORD_BITS-1:0] t_word;

    // Micro-op program: 28 multiplies per RK4 step
    localparam int UOP_BITS = 5;
    localparam logic [UOP_BITS-1:0] UOP_LAST = 5'd27;

    typedef enum logic [3:0] {
        OPA_KX, OPA_KY, OPA_KZ, OPA_TX, OPA_TY, OPA_TZ, OPA_SIGMA, OPA_BETA, OPA_PX
    } t_opa;

    typedef enum logic [2:0] {
        OPB_H2, OPB_H, OPB_H6, OPB_YX, OPB_RZ, OPB_PY, OPB_PZ
    } t_opb;

    typedef enum logic [3:0] {
        DST_PX, DST_PY, DST_PZ, DST_KX, DST_KY, DST_TMP, DST_KZ, DST_SX, DST_SY, DST_SZ
    } t_dst;

    typedef enum logic [1:0] {
        ACC_NONE, ACC_SET, ACC_DBL, ACC_ONE
    } t_acc;

    typedef struct packed {
        t_opa opa;
        t_opb opb;
        t_dst dst;
        t_acc acc;
    } t_uop;

    // Derivative evaluation, four multiplies
    function automatic t_uop uop_deriv(input logic [1:0] n, input t_acc acc);
        t_uop u;
        begin
            u.acc = ACC_NONE;
            unique case (n)
                2'd0: begin u.opa = OPA_SIGMA; u.opb = OPB_YX; u.dst = DST_KX; end
                2'd1: begin u.opa = OPA_PX;    u.opb = OPB_RZ; u.dst = DST_KY; end
                2'd2: begin u.opa = OPA_PX;    u.opb = OPB_PY; u.dst = DST_TMP; end
                default: begin
                    u.opa = OPA_BETA; u.opb = OPB_PZ; u.dst = DST_KZ; u.acc = acc;
                end
            endcase
            return u;
        end
    endfunction

    // Stage point p = s + k*c
    function automatic t_uop uop_axpy(input logic [1:0] n, input t_opb c);
        t_uop u;
        begin
            u.opb = c;
            u.acc = ACC_NONE;
            unique case (n)
                2'd0:    begin u.opa = OPA_KX; u.dst = DST_PX; end
                2'd1:    begin u.opa = OPA_KY; u.dst = DST_PY; end
                default: begin u.opa = OPA_KZ; u.dst = DST_PZ; end
            endcase
            return u;
        end
    endfunction

    // Final update s = s + t*h/6
    function automatic t_uop uop_final(input logic [1:0] n);
        t_uop u;
        begin
            u.opb = OPB_H6;
            u.acc = ACC_NONE;
            unique case (n)
                2'd0:    begin u.opa = OPA_TX; u.dst = DST_SX; end
                2'd1:    begin u.opa = OPA_TY; u.dst = DST_SY; end
                default: begin u.opa = OPA_TZ; u.dst = DST_SZ; end
            endcase
            return u;
        end
    endfunction

    function automatic t_uop uop_decode(input logic [UOP_BITS-1:0] idx);
        t_uop u;
        begin
            unique case (idx)
                5'd0:  u = uop_deriv(2'd0, ACC_SET);
                5'd1:  u = uop_deriv(2'd1, ACC_SET);
                5'd2:  u = uop_deriv(2'd2, ACC_SET);
                5'd3:  u = uop_deriv(2'd3, ACC_SET);
                5'd4:  u = uop_axpy(2'd0, OPB_H2);
                5'd5:  u = uop_axpy(2'd1, OPB_H2);
                5'd6:  u = uop_axpy(2'd2, OPB_H2);
                5'd7:  u = uop_deriv(2'd0, ACC_DBL);
                5'd8:  u = uop_deriv(2'd1, ACC_DBL);
                5'd9:  u = uop_deriv(2'd2, ACC_DBL);
                5'd10: u = uop_deriv(2'd3, ACC_DBL);
                5'd11: u = uop_axpy(2'd0, OPB_H2);
                5'd12: u = uop_axpy(2'd1, OPB_H2);
                5'd13: u = uop_axpy(2'd2, OPB_H2);
                5'd14: u = uop_deriv(2'd0, ACC_DBL);
                5'd15: u = uop_deriv(2'd1, ACC_DBL);
                5'd16: u = uop_deriv(2'd2, ACC_DBL);
                5'd17: u = uop_deriv(2'd3, ACC_DBL);
                5'd18: u = uop_axpy(2'd0, OPB_H);
                5'd19: u = uop_axpy(2'd1, OPB_H);
                5'd20: u = uop_axpy(2'd2, OPB_H);
                5'd21: u = uop_deriv(2'd0, ACC_ONE);
                5'd22: u = uop_deriv(2'd1, ACC_ONE);
                5'd23: u = uop_deriv(2'd2, ACC_ONE);
                5'd24: u = uop_deriv(2'd3, ACC_ONE);
                5'd25: u = uop_final(2'd0);
                5'd26: u = uop_final(2'd1);
                default: u = uop_final(2'd2);
            endcase
            return u;
        end
    endfunction

endpackage

// File: sv/lorenz_rk4_divergence_tracker_top.sv
// Lorenz RK4 divergence tracker: sequencer, state registers and result register.
//
//   channel  direction  handshake                      beat
//   in       sink       i_in_valid / o_in_ready        mode, load point
//   out      source     o_out_valid / i_out_ready      both states, separation, index
//   cfg      sink       i_cfg_we (no wait)             register index, value
//
// Every multiply runs on one shared 24x24 unit, four partial products.
// An RK4 step is 28 multiplies; h/6 takes one more multiply.
// Separation: 3 multiplies plus a square root.
// o_in_ready is high only when the sequencer is idle; synchronous reset restores the
// register defaults and clears both trajectories and the record index.
`timescale 1ns / 1ps

module lorenz_rk4_divergence_tracker_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_mode,
    input  logic signed [lrt_pkg::WORD_BITS-1:0]  i_load_x,
    input  logic signed [lrt_pkg::WORD_BITS-1:0]  i_load_y,
    input  logic signed [lrt_pkg::WORD_BITS-1:0]  i_load_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [lrt_pkg::WORD_BITS-1:0]  o_first_x,
    output logic signed [lrt_pkg::WORD_BITS-1:0]  o_first_y,
    output logic signed [lrt_pkg::WORD_BITS-1:0]  o_first_z,
    output logic signed [lrt_pkg::WORD_BITS-1:0]  o_second_x,
    output logic signed [lrt_pkg::WORD_BITS-1:0]  o_second_y,
    output logic signed [lrt_pkg::WORD_BITS-1:0]  o_second_z,
    output logic [lrt_pkg::WORD_BITS-1:0]         o_separation,
    output logic [lrt_pkg::CNT_BITS-1:0]          o_record_index,
    input  logic                                  i_cfg_we,
    input  logic [2:0]                            i_cfg_idx,
    input  logic [lrt_pkg::COEF_BITS-1:0]         i_cfg_data
);

    localparam int W  = lrt_pkg::WORD_BITS;
    localparam int CB = lrt_pkg::COEF_BITS;
    localparam int SB = lrt_pkg::STEP_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_ISSUE, S_WAIT, S_ACC, S_H6_ISSUE, S_H6_WAIT,
        S_SEP_ISSUE, S_SEP_WAIT, S_SQRT_ISSUE, S_SQRT_WAIT, S_EMIT
    } t_state;

    // saturating add / subtract on the word
    function automatic lrt_pkg::t_word f_add(input lrt_pkg::t_word a, input lrt_pkg::t_word b);
        logic signed [W:0] s;
        begin
            s = {a[W-1], a} + {b[W-1], b};
            if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            return s[W-1:0];
        end
    endfunction

    function automatic lrt_pkg::t_word f_sub(input lrt_pkg::t_word a, input lrt_pkg::t_word b);
        logic signed [W:0] s;
        begin
            s = {a[W-1], a} - {b[W-1], b};
            if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            return s[W-1:0];
        end
    endfunction

    function automatic logic [W-1:0] f_mag(input lrt_pkg::t_word v);
        begin
            return v[W-1] ? (~v + W'(1)) : v;
        end
    endfunction

    t_state                          r_state;
    logic [1:0]                      r_mode;
    logic                            r_tsel;
    logic [lrt_pkg::UOP_BITS-1:0]    r_uop;
    logic [1:0]                      r_sep_i;
    logic [CB-1:0]                   r_sigma, r_rho, r_beta;
    logic [SB-1:0]                   r_step, r_offset;
    lrt_pkg::t_word                  r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [lrt_pkg::CNT_BITS-1:0]    r_rec;
    lrt_pkg::t_word                  r_px, r_py, r_pz, r_kx, r_ky, r_kz;
    lrt_pkg::t_word                  r_tx, r_ty, r_tz, r_tmp, r_h6;
    logic [lrt_pkg::SSQ_BITS-1:0]    r_ssq;
    logic [W-1:0]                    r_sep;
    logic                            r_ov;
    lrt_pkg::t_word                  r_o_ax, r_o_ay, r_o_az, r_o_bx, r_o_by, r_o_bz;
    logic [W-1:0]                    r_o_sep;
    logic [lrt_pkg::CNT_BITS-1:0]    r_o_rec;

    lrt_pkg::t_uop                   w_uop;
    lrt_pkg::t_word                  w_sx, w_sy, w_sz, w_opa, w_opb, w_fx;
    lrt_pkg::t_word                  w_da, w_db;
    logic signed [W:0]               w_d, w_dn;
    logic [W-1:0]                    w_mag_a, w_mag_b;
    logic                            w_neg, w_mul_start, w_mul_done;
    logic [lrt_pkg::PROD_BITS-1:0]   w_prod;
    logic                            w_sqrt_done;
    logic [W-1:0]                    w_root;

    assign w_uop = lrt_pkg::uop_decode(r_uop);

    // trajectory under integration
    assign w_sx = r_tsel ? r_bx : r_ax;
    assign w_sy = r_tsel ? r_by : r_ay;
    assign w_sz = r_tsel ? r_bz : r_az;

    // multiplier operand select
    always_comb begin
        unique case (w_uop.opa)
            lrt_pkg::OPA_KX:    w_opa = r_kx;
            lrt_pkg::OPA_KY:    w_opa = r_ky;
            lrt_pkg::OPA_KZ:    w_opa = r_kz;
            lrt_pkg::OPA_TX:    w_opa = r_tx;
            lrt_pkg::OPA_TY:    w_opa = r_ty;
            lrt_pkg::OPA_TZ:    w_opa = r_tz;
            lrt_pkg::OPA_SIGMA: w_opa = {1'b0, r_sigma};
            lrt_pkg::OPA_BETA:  w_opa = {1'b0, r_beta};
            default:            w_opa = r_px;
        endcase
        unique case (w_uop.opb)
            lrt_pkg::OPB_H2: w_opb = {{(W-SB+1){1'b0}}, r_step[SB-1:1]};
            lrt_pkg::OPB_H:  w_opb = {{(W-SB){1'b0}}, r_step};
            lrt_pkg::OPB_H6: w_opb = r_h6;
            lrt_pkg::OPB_YX: w_opb = f_sub(r_py, r_px);
            lrt_pkg::OPB_RZ: w_opb = f_sub({1'b0, r_rho}, r_pz);
            lrt_pkg::OPB_PY: w_opb = r_py;
            default:         w_opb = r_pz;
        endcase
    end

    // separation coordinate difference, exact magnitude
    always_comb begin
        case (r_sep_i)
            2'd0:    begin w_da = r_ax; w_db = r_bx; end
            2'd1:    begin w_da = r_ay; w_db = r_by; end
            default: begin w_da = r_az; w_db = r_bz; end
        endcase
        w_d  = {w_da[W-1], w_da} - {w_db[W-1], w_db};
        w_dn = -w_d;
    end

    // multiplier issue
    always_comb begin
        w_mul_start = 1'b0;
        w_mag_a     = f_mag(w_opa);
        w_mag_b     = f_mag(w_opb);
        w_neg       = w_opa[W-1] ^ w_opb[W-1];
        case (r_state)
            S_ISSUE: w_mul_start = 1'b1;
            S_H6_ISSUE: begin
                w_mul_start = 1'b1;
                w_mag_a     = {{(W-SB){1'b0}}, r_step};
                w_mag_b     = W'(lrt_pkg::H6_MAGIC);
                w_neg       = 1'b0;
            end
            S_SEP_ISSUE: begin
                w_mul_start = 1'b1;
                w_mag_a     = w_d[W] ? w_dn[W-1:0] : w_d[W-1:0];
                w_mag_b     = w_d[W] ? w_dn[W-1:0] : w_d[W-1:0];
                w_neg       = 1'b0;
            end
            default: ;
        endcase
    end

    lrt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_mag_a (w_mag_a),
        .i_mag_b (w_mag_b),
        .i_neg   (w_neg),
        .o_done  (w_mul_done),
        .o_prod  (w_prod),
        .o_fx    (w_fx)
    );

    lrt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQRT_ISSUE),
        .i_rad   (r_ssq),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // sequencer, state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= lrt_pkg::MODE_LOAD;
            r_tsel   <= 1'b0;
            r_uop    <= '0;
            r_sep_i  <= 2'd0;
            r_ov     <= 1'b0;
            r_sigma  <= lrt_pkg::SIGMA_RST;
            r_rho    <= lrt_pkg::RHO_RST;
            r_beta   <= lrt_pkg::BETA_RST;
            r_step   <= lrt_pkg::STEP_RST;
            r_offset <= lrt_pkg::OFFSET_RST;
            r_ax     <= '0;
            r_ay     <= '0;
            r_az     <= '0;
            r_bx     <= '0;
            r_by     <= '0;
            r_bz     <= '0;
            r_rec    <= '0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lrt_pkg::CFG_SIGMA:  r_sigma  <= i_cfg_data;
                    lrt_pkg::CFG_RHO:    r_rho    <= i_cfg_data;
                    lrt_pkg::CFG_BETA:   r_beta   <= i_cfg_data;
                    lrt_pkg::CFG_STEP:   r_step   <= i_cfg_data[SB-1:0];
                    lrt_pkg::CFG_OFFSET: r_offset <= i_cfg_data[SB-1:0];
                    default: ;
                endcase
            end

            // result taken; S_EMIT refills the register itself
            if (r_ov && i_out_ready && r_state != S_EMIT) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= i_mode;
                        r_sep_i <= 2'd0;
                        r_ssq   <= '0;
                        r_tsel  <= 1'b0;
                        if (i_mode == lrt_pkg::MODE_LOAD) begin
                            r_ax    <= i_load_x;
                            r_ay    <= i_load_y;
                            r_az    <= i_load_z;
                            r_bx    <= f_add(i_load_x, {{(W-SB){1'b0}}, r_offset});
                            r_by    <= i_load_y;
                            r_bz    <= i_load_z;
                            r_rec   <= '0;
                            r_state <= S_SEP_ISSUE;
                        end else if (i_mode == lrt_pkg::MODE_WARM) begin
                            r_state <= S_H6_ISSUE;
                        end else begin
                            r_state <= S_SEP_ISSUE;
                        end
                    end
                end
                S_H6_ISSUE: r_state <= S_H6_WAIT;
                S_H6_WAIT: begin
                    if (w_mul_done) begin
                        r_h6    <= {{(W-SB){1'b0}}, w_prod[lrt_pkg::H6_SHIFT+SB-1:lrt_pkg::H6_SHIFT]};
                        r_tsel  <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_px    <= w_sx;
                    r_py    <= w_sy;
                    r_pz    <= w_sz;
                    r_uop   <= '0;
                    r_state <= S_ISSUE;
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_mul_done) begin
                        unique case (w_uop.dst)
                            lrt_pkg::DST_PX:  r_px  <= f_add(w_sx, w_fx);
                            lrt_pkg::DST_PY:  r_py  <= f_add(w_sy, w_fx);
                            lrt_pkg::DST_PZ:  r_pz  <= f_add(w_sz, w_fx);
                            lrt_pkg::DST_KX:  r_kx  <= w_fx;
                            lrt_pkg::DST_KY:  r_ky  <= f_sub(w_fx, r_py);
                            lrt_pkg::DST_TMP: r_tmp <= w_fx;
                            lrt_pkg::DST_KZ:  r_kz  <= f_sub(r_tmp, w_fx);
                            lrt_pkg::DST_SX: begin
                                if (r_tsel) r_bx <= f_add(w_sx, w_fx);
                                else        r_ax <= f_add(w_sx, w_fx);
                            end
                            lrt_pkg::DST_SY: begin
                                if (r_tsel) r_by <= f_add(w_sy, w_fx);
                                else        r_ay <= f_add(w_sy, w_fx);
                            end
                            default: begin
                                if (r_tsel) r_bz <= f_add(w_sz, w_fx);
                                else        r_az <= f_add(w_sz, w_fx);
                            end
                        endcase
                        if (w_uop.acc != lrt_pkg::ACC_NONE) begin
                            r_state <= S_ACC;
                        end else if (r_uop != lrt_pkg::UOP_LAST) begin
                            r_uop   <= r_uop + 1'b1;
                            r_state <= S_ISSUE;
                        end else if (r_mode == lrt_pkg::MODE_WARM) begin
                            r_sep_i <= 2'd0;
                            r_ssq   <= '0;
                            r_state <= S_SEP_ISSUE;
                        end else if (!r_tsel) begin
                            r_tsel  <= 1'b1;
                            r_state <= S_LOAD;
                        end else begin
                            r_rec   <= r_rec + 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ACC: begin
                    // weighted sum k1 + 2k2 + 2k3 + k4, left to right
                    case (w_uop.acc)
                        lrt_pkg::ACC_SET: begin
                            r_tx <= r_kx;
                            r_ty <= r_ky;
                            r_tz <= r_kz;
                        end
                        lrt_pkg::ACC_DBL: begin
                            r_tx <= f_add(r_tx, f_add(r_kx, r_kx));
                            r_ty <= f_add(r_ty, f_add(r_ky, r_ky));
                            r_tz <= f_add(r_tz, f_add(r_kz, r_kz));
                        end
                        default: begin
                            r_tx <= f_add(r_tx, r_kx);
                            r_ty <= f_add(r_ty, r_ky);
                            r_tz <= f_add(r_tz, r_kz);
                        end
                    endcase
                    r_uop   <= r_uop + 1'b1;
                    r_state <= S_ISSUE;
                end
                S_SEP_ISSUE: r_state <= S_SEP_WAIT;
                S_SEP_WAIT: begin
                    if (w_mul_done) begin
                        r_ssq <= r_ssq + {2'b00, w_prod};
                        if (r_sep_i == 2'd2) begin
                            r_state <= S_SQRT_ISSUE;
                        end else begin
                            r_sep_i <= r_sep_i + 2'd1;
                            r_state <= S_SEP_ISSUE;
                        end
                    end
                end
                S_SQRT_ISSUE: r_state <= S_SQRT_WAIT;
                S_SQRT_WAIT: begin
                    if (w_sqrt_done) begin
                        r_sep   <= w_root;
                        r_state <= S_EMIT;
                    end
                end
                default: begin
                    // S_EMIT: wait for the result register to free up
                    if (!r_ov || i_out_ready) begin
                        r_o_ax  <= r_ax;
                        r_o_ay  <= r_ay;
                        r_o_az  <= r_az;
                        r_o_bx  <= r_bx;
                        r_o_by  <= r_by;
                        r_o_bz  <= r_bz;
                        r_o_sep <= r_sep;
                        r_o_rec <= r_rec;
                        r_ov    <= 1'b1;
                        if (r_mode == lrt_pkg::MODE_RECORD) r_state <= S_H6_ISSUE;
                        else                                r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_ov;
    assign o_first_x      = r_o_ax;
    assign o_first_y      = r_o_ay;
    assign o_first_z      = r_o_az;
    assign o_second_x     = r_o_bx;
    assign o_second_y     = r_o_by;
    assign o_second_z     = r_o_bz;
    assign o_separation   = r_o_sep;
    assign o_record_index = r_o_rec;

    // multiplier results only arrive while the sequencer waits for them
    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_WAIT || r_state == S_H6_WAIT || r_state == S_SEP_WAIT))
        else $error("multiplier finished outside a wait state");

    a_sqrt_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> (r_state == S_SQRT_WAIT))
        else $error("square root finished outside its wait state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an accepted beat");

    a_uop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_uop <= lrt_pkg::UOP_LAST)
        else $error("micro-op index past the end of the program");

endmodule

// File: sv/lrt_mul.sv
// Shared multiplier: 48x48 magnitude product from four 24x24 partial products.
`timescale 1ns / 1ps

module lrt_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [lrt_pkg::WORD_BITS-1:0]     i_mag_a,
    input  logic [lrt_pkg::WORD_BITS-1:0]     i_mag_b,
    input  logic                              i_neg,
    output logic                              o_done,
    output logic [lrt_pkg::PROD_BITS-1:0]     o_prod,
    output lrt_pkg::t_word                    o_fx
);

    localparam int W = lrt_pkg::WORD_BITS;
    localparam int H = lrt_pkg::HALF_BITS;
    localparam int P = lrt_pkg::PROD_BITS;
    localparam int F = lrt_pkg::FRAC_BITS;
    localparam int Q = P + 1 - F;

    logic [W-1:0]    r_a, r_b;
    logic            r_neg;
    logic [P-1:0]    r_acc;
    logic [2*H-1:0]  r_pp;
    logic [1:0]      r_ppsh;
    logic            r_ppv;
    logic [2:0]      r_ph;
    logic            r_busy;
    logic            r_done;
    lrt_pkg::t_word  r_fx;

    logic [H-1:0]    w_ha, w_hb;
    logic [P-1:0]    w_ppx;
    logic [P:0]      w_rnd;
    logic [Q-1:0]    w_q;
    logic [W-1:0]    w_qn;
    lrt_pkg::t_word  w_fx;

    // partial product select: phase bit 1 picks the half of a, bit 0 the half of b
    assign w_ha = r_ph[1] ? r_a[W-1:H] : r_a[H-1:0];
    assign w_hb = r_ph[0] ? r_b[W-1:H] : r_b[H-1:0];

    // align the registered partial product
    always_comb begin
        case (r_ppsh)
            2'd0:    w_ppx = {{(P-2*H){1'b0}}, r_pp};
            2'd1:    w_ppx = {{(P-3*H){1'b0}}, r_pp, {H{1'b0}}};
            default: w_ppx = {r_pp, {(P-2*H){1'b0}}};
        endcase
    end

    // round half away from zero, apply sign, saturate
    always_comb begin
        w_rnd = {1'b0, r_acc} + ((P+1)'(1) << (F - 1));
        w_q   = w_rnd[P:F];
        w_qn  = ~w_q[W-1:0] + W'(1);
        if (!r_neg) begin
            if (w_q[Q-1:W-1] != '0) w_fx = {1'b0, {(W-1){1'b1}}};
            else                    w_fx = w_q[W-1:0];
        end else begin
            if (w_q[Q-1:W] != '0 || (w_q[W-1] && w_q[W-2:0] != '0))
                w_fx = {1'b1, {(W-1){1'b0}}};
            else
                w_fx = w_qn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
            r_ph   <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_mag_a;
                r_b    <= i_mag_b;
                r_neg  <= i_neg;
                r_acc  <= '0;
                r_ph   <= 3'd0;
                r_ppv  <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // four multiply phases, then drain, then round
                if (r_ph <= 3'd3) begin
                    r_pp   <= w_ha * w_hb;
                    r_ppsh <= 2'({1'b0, r_ph[1]} + {1'b0, r_ph[0]});
                    r_ppv  <= 1'b1;
                end else begin
                    r_ppv <= 1'b0;
                end
                if (r_ppv) r_acc <= r_acc + w_ppx;
                if (r_ph == 3'd5) begin
                    r_fx   <= w_fx;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
                r_ph <= r_ph + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
    assign o_fx   = r_fx;

endmodule

// File: sv/lrt_sqrt.sv
// Bit-serial integer square root, one result bit per cycle, saturated to 48 bits.
`timescale 1ns / 1ps

module lrt_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [lrt_pkg::SSQ_BITS-1:0]      i_rad,
    output logic                              o_done,
    output logic [lrt_pkg::WORD_BITS-1:0]     o_root
);

    localparam int R  = lrt_pkg::ROOT_BITS;
    localparam int RB = 2 * R;
    localparam int W  = lrt_pkg::WORD_BITS;

    logic [RB-1:0]  r_rad;
    logic [R+1:0]   r_rem;
    logic [R-1:0]   r_root;
    logic [5:0]     r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [R+3:0]   w_remx;
    logic [R+3:0]   w_trial;
    logic [R+3:0]   w_diff;
    logic           w_ge;

    // one restoring step
    assign w_remx  = {r_rem, r_rad[RB-1:RB-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_remx >= w_trial);
    assign w_diff  = w_remx - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= {{(RB-lrt_pkg::SSQ_BITS){1'b0}}, i_rad};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[RB-3:0], 2'b00};
                r_rem  <= w_ge ? w_diff[R+1:0] : w_remx[R+1:0];
                r_root <= {r_root[R-2:0], w_ge};
                if (r_cnt == 6'(R - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = (r_root[R-1:W] != '0) ? {W{1'b1}} : r_root[W-1:0];

endmodule
